// ===== rtl/masked_byte_pattern_scan_defines.svh =====
// ----------------------------------------------------------------------------
// Masked byte pattern scan: assertion macros
// Check macros clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCAN_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCAN_DEFINES_SVH

`ifndef SYNTH
// cond must hold at every edge
`define MBPS_CHECK(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("mbps check failed");
// cause in this cycle implies effect in the next
`define MBPS_CHECK_NEXT(lbl, cause, effect) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error("mbps check failed");
`else
`define MBPS_CHECK(lbl, cond)
`define MBPS_CHECK_NEXT(lbl, cause, effect)
`endif

`endif

// ===== rtl/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// Masked byte pattern scan package
// Sizes, register indexes and shared types of the scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

	localparam int MAX_PATTERN = 32;
	localparam int OFFSET_BITS = 32;
	localparam int RES_W       = 32;
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int RAW_LEN_W   = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LOW      = 3'd0,
		REG_PAT_MID_LOW  = 3'd1,
		REG_PAT_MID_HIGH = 3'd2,
		REG_PAT_HIGH     = 3'd3,
		REG_WILDCARD     = 3'd4,
		REG_PAT_LEN      = 3'd5
	} reg_idx_t;

	typedef logic [7:0]               pbyte_t;
	typedef pbyte_t [MAX_PATTERN-1:0] pat_arr_t;
	typedef logic [MAX_PATTERN-1:0]   lane_vec_t;

	typedef struct packed {
		logic advance;
		logic clear;
	} cell_ctrl_t;

	typedef struct packed {
		logic             found;
		logic [RES_W-1:0] offset;
	} result_t;

	typedef struct packed {
		logic head_valid;
		logic skid_valid;
	} buf_status_t;

	function automatic logic [LEN_W-1:0] used_len(input logic [RAW_LEN_W-1:0] raw);
		logic [LEN_W-1:0] n;
		if (raw == '0) begin
			n = LEN_W'(1);
		end else if (raw > RAW_LEN_W'(MAX_PATTERN)) begin
			n = LEN_W'(MAX_PATTERN);
		end else begin
			n = raw[LEN_W-1:0];
		end
		return n;
	endfunction

endpackage

// ===== rtl/mbps_cell.sv =====
// ----------------------------------------------------------------------------
// Masked byte pattern scan: one pattern position
// Holds one prefix-match bit and passes it to the next position.
// ----------------------------------------------------------------------------
module mbps_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  mbps_pkg::cell_ctrl_t ctrl,
	input  mbps_pkg::pbyte_t    data_byte,
	input  mbps_pkg::pbyte_t    pat_byte,
	input  logic                wild,
	input  logic                in_use,
	input  logic                prev_bit,
	output logic                bit_q,
	output logic                bit_next
);
	import mbps_pkg::*;

	assign bit_next = prev_bit & in_use & (wild | (pat_byte == data_byte));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctrl.clear) begin
			bit_q <= 1'b0;
		end else if (ctrl.advance) begin
			bit_q <= bit_next;
		end
	end

endmodule

// ===== rtl/mbps_cell_row.sv =====
// ----------------------------------------------------------------------------
// Masked byte pattern scan: row of cells
// Shift-and chain over all pattern positions and full-length hit detect.
// ----------------------------------------------------------------------------
module mbps_cell_row (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mbps_pkg::cell_ctrl_t ctrl,
	input  mbps_pkg::pbyte_t     data_byte,
	input  mbps_pkg::pat_arr_t   pat,
	input  mbps_pkg::lane_vec_t  wild,
	input  mbps_pkg::lane_vec_t  use_mask,
	input  mbps_pkg::lane_vec_t  last_sel,
	output logic                 hit
);
	import mbps_pkg::*;

	lane_vec_t state_q;
	lane_vec_t state_next;
	lane_vec_t prev_vec;

	assign prev_vec = {state_q[MAX_PATTERN-2:0], 1'b1};

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		mbps_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.data_byte (data_byte),
			.pat_byte  (pat[j]),
			.wild      (wild[j]),
			.in_use    (use_mask[j]),
			.prev_bit  (prev_vec[j]),
			.bit_q     (state_q[j]),
			.bit_next  (state_next[j])
		);
	end

	assign hit = |(state_next & last_sel);

endmodule

// ===== rtl/mbps_out_buf.sv =====
// ----------------------------------------------------------------------------
// Masked byte pattern scan: result buffer
// Output register with one skid entry behind it.
// ----------------------------------------------------------------------------
module mbps_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mbps_pkg::result_t     push_data,
	input  logic                  out_ready,
	output mbps_pkg::result_t     head,
	output mbps_pkg::buf_status_t status
);
	import mbps_pkg::*;

	logic    head_valid_q;
	logic    skid_valid_q;
	result_t head_q;
	result_t skid_q;
	logic    pop;

	assign pop    = head_valid_q & out_ready;
	assign head   = head_q;
	assign status = '{head_valid: head_valid_q, skid_valid: skid_valid_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				head_valid_q <= 1'b1;
				skid_valid_q <= push;
			end else begin
				head_valid_q <= push;
			end
		end else if (push) begin
			if (!head_valid_q) begin
				head_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
				skid_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end else if (push) begin
			if (!head_valid_q) begin
				head_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

// ===== rtl/masked_byte_pattern_scan.sv =====
// A result is pushed into the registered output buffer when the byte that ends the window is accepted.
// Throughput: one byte per cycle; the shift-and row of cells updates in a single step.
// Input stalls only while two results wait (output register and skid entry both full).
// Reset (arst_n low) clears the match vector, offset and report flag at once;
// registers return to zero pattern, no wildcards, length one. No clearing pass.
// ----------------------------------------------------------------------------
// Masked byte pattern scan
// Finds the first window of a region matching a byte pattern with wildcards.
// ----------------------------------------------------------------------------
`include "masked_byte_pattern_scan_defines.svh"

module masked_byte_pattern_scan (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          data_byte,
	input  logic                                last_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                found,
	output logic [mbps_pkg::RES_W-1:0]          match_offset
);
	import mbps_pkg::*;

	pat_arr_t         pat_q;
	lane_vec_t        wild_q;
	lane_vec_t        use_mask_q;
	lane_vec_t        last_sel_q;
	logic [LEN_W-1:0] len_m1_q;
	logic [LEN_W-1:0] cfg_len;

	logic [OFFSET_BITS-1:0] offset_q;
	logic [OFFSET_BITS-1:0] start_offset;
	logic                   reported_q;

	logic        cfg_acc;
	logic        in_acc;
	logic        hit;
	logic        push;
	cell_ctrl_t  ctrl;
	result_t     push_data;
	result_t     head;
	buf_status_t buf_st;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign cfg_len   = used_len(cfg_data[RAW_LEN_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q      <= '0;
			wild_q     <= '0;
			use_mask_q <= lane_vec_t'(1);
			last_sel_q <= lane_vec_t'(1);
			len_m1_q   <= '0;
		end else if (cfg_acc) begin
			case (reg_idx_t'(cfg_index))
				REG_PAT_LOW, REG_PAT_MID_LOW, REG_PAT_MID_HIGH, REG_PAT_HIGH: begin
					for (int j = 0; j < MAX_PATTERN; j++) begin
						if (2'(j / 8) == cfg_index[1:0]) begin
							pat_q[j] <= cfg_data[(j % 8) * 8 +: 8];
						end
					end
				end
				REG_WILDCARD: begin
					wild_q <= cfg_data[MAX_PATTERN-1:0];
				end
				REG_PAT_LEN: begin
					for (int j = 0; j < MAX_PATTERN; j++) begin
						use_mask_q[j] <= (LEN_W'(j) < cfg_len);
						last_sel_q[j] <= (LEN_W'(j) == cfg_len - LEN_W'(1));
					end
					len_m1_q <= cfg_len - LEN_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	assign in_ready = !buf_st.skid_valid;
	assign in_acc   = in_valid & in_ready;

	assign ctrl = '{advance: in_acc & !reported_q, clear: in_acc & last_byte};

	mbps_cell_row u_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.data_byte (data_byte),
		.pat       (pat_q),
		.wild      (wild_q),
		.use_mask  (use_mask_q),
		.last_sel  (last_sel_q),
		.hit       (hit)
	);

	assign start_offset     = offset_q - OFFSET_BITS'(len_m1_q);
	assign push             = ctrl.advance & (hit | last_byte);
	assign push_data.found  = hit;
	assign push_data.offset = hit ? RES_W'(start_offset) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= '0;
			reported_q <= 1'b0;
		end else if (ctrl.clear) begin
			offset_q   <= '0;
			reported_q <= 1'b0;
		end else if (in_acc) begin
			offset_q <= offset_q + OFFSET_BITS'(1);
			if (ctrl.advance & hit) begin
				reported_q <= 1'b1;
			end
		end
	end

	mbps_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.out_ready (out_ready),
		.head      (head),
		.status    (buf_st)
	);

	assign out_valid    = buf_st.head_valid;
	assign found        = head.found;
	assign match_offset = head.offset;

	`MBPS_CHECK(a_skid_behind_head, !buf_st.skid_valid || buf_st.head_valid)
	`MBPS_CHECK(a_no_result_after_report, !(reported_q && push))
	`MBPS_CHECK_NEXT(a_region_end_clears, in_acc && last_byte, !reported_q && offset_q == '0)
	`MBPS_CHECK_NEXT(a_push_shows_output, push, out_valid)

endmodule

// ===== test/masked_byte_pattern_scan_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Masked byte pattern scan testbench
// Streams regions with planted and partial patterns through the scanner,
// predicts each first-match or not-found result, and checks every result
// in order while both handshakes idle at random, but for one steady phase.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan_test;
	import mbps_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
	localparam int IDLE_PCT  = 27;
	localparam int REPORT_MAX = 10;

	class match_scoreboard;
		pat_arr_t               pattern;
		lane_vec_t              wild;
		logic [RAW_LEN_W-1:0]   raw_len;
		lane_vec_t              prefix;
		logic [OFFSET_BITS-1:0] pos;
		bit                     reported;
		result_t                pending_results[$];
		int                     errors;

		function new();
			pattern  = '0;
			wild     = '0;
			raw_len  = RAW_LEN_W'(1);
			errors   = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			prefix   = '0;
			pos      = '0;
			reported = 1'b0;
		endfunction

		function int pattern_span();
			int n;
			n = int'(raw_len);
			if (n == 0) n = 1;
			if (n > MAX_PATTERN) n = MAX_PATTERN;
			return n;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_PAT_LOW:      pattern[7:0]   = d;
				REG_PAT_MID_LOW:  pattern[15:8]  = d;
				REG_PAT_MID_HIGH: pattern[23:16] = d;
				REG_PAT_HIGH:     pattern[31:24] = d;
				REG_WILDCARD:     wild           = d[MAX_PATTERN-1:0];
				REG_PAT_LEN:      raw_len        = d[RAW_LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_byte(pbyte_t b, logic l);
			int        n;
			lane_vec_t acc;
			result_t   r;
			n   = pattern_span();
			acc = '0;
			for (int j = 0; j < n; j++) begin
				if (wild[j] || pattern[j] == b) acc[j] = 1'b1;
			end
			if (!reported) begin
				prefix = lane_vec_t'((prefix << 1) | lane_vec_t'(1)) & acc;
				if (prefix[n-1]) begin
					r.found  = 1'b1;
					r.offset = RES_W'(pos - OFFSET_BITS'(n - 1));
					pending_results.push_back(r);
					reported = 1'b1;
				end else if (l) begin
					r.found  = 1'b0;
					r.offset = '0;
					pending_results.push_back(r);
				end
			end
			pos = pos + OFFSET_BITS'(1);
			if (l) clear_scan();
		endfunction

		function void check_result(logic f, logic [RES_W-1:0] o);
			result_t e;
			if (pending_results.size() == 0) begin
				if (errors < REPORT_MAX)
					$display("unexpected result: found=%0b offset=%0d", f, o);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (e.found !== f || e.offset !== o) begin
					if (errors < REPORT_MAX)
						$display("mismatch: expected found=%0b offset=%0d, got found=%0b offset=%0d",
							e.found, e.offset, f, o);
					errors++;
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            data_byte;
	logic                  last_byte;
	logic                  out_valid;
	logic                  out_ready;
	logic                  found;
	logic [RES_W-1:0]      match_offset;

	match_scoreboard board = new();
	bit              steady;
	int              items_sent;

	masked_byte_pattern_scan dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.match_offset (match_offset)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_result(found, match_offset);
	end

	task automatic send_byte(input pbyte_t b, input logic l);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.take_byte(b, l);
		items_sent++;
	endtask

	// hold input until every result is out, then let the pipeline settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] pattern_word(input int style);
		logic [63:0] w;
		case (style)
			0: w = {$urandom, $urandom};
			1: for (int k = 0; k < 8; k++) w[8*k +: 8] = $urandom_range(1) ? 8'h41 : 8'h42;
			2: w = '0;
			default: w = '1;
		endcase
		return w;
	endfunction

	// where the region can hold it, maybe plant the pattern; pad with pattern or random bytes
	task automatic scan_region(input int span);
		int     n;
		int     at;
		bit     plant;
		pbyte_t b;
		n     = board.pattern_span();
		plant = (span >= n) && ($urandom_range(99) < 60);
		at    = 0;
		if (plant) at = ($urandom_range(3) == 0) ? span - n : $urandom_range(span - n);
		for (int i = 0; i < span; i++) begin
			if (plant && i >= at && i < at + n)
				b = board.wild[i - at] ? pbyte_t'($urandom) : board.pattern[i - at];
			else if ($urandom_range(1))
				b = board.pattern[$urandom_range(n - 1)];
			else
				b = pbyte_t'($urandom);
			send_byte(b, i == span - 1);
		end
	endtask

	initial begin
		#2_000_000;
		$display("FAIL masked_byte_pattern_scan");
		$finish;
	end

	initial begin
		int style;
		int span;
		int goal;
		logic [CFG_DATA_W-1:0] len_word;

		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_PAT_LOW;
		cfg_data   = '0;
		in_valid   = 1'b0;
		data_byte  = '0;
		last_byte  = 1'b0;
		out_ready  = 1'b0;
		steady     = 1'b0;
		items_sent = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset pattern: one zero byte; report once, then silence to region end
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);

		// wildcard in the middle, match completed by the last byte
		write_reg(REG_PAT_LOW, 64'h0000_0000_4400_4241);
		write_reg(REG_WILDCARD, 64'hFFFF_FFFF_0000_0004);
		write_reg(REG_PAT_LEN, 64'h0000_0000_0000_0004);
		send_byte(8'h41, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b0);
		send_byte(8'h77, 1'b0);
		send_byte(8'h44, 1'b1);

		// zero length acts as one
		write_reg(REG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFC0);
		send_byte(8'h41, 1'b1);

		// oversize length acts as full width; short region cannot hold a window
		write_reg(REG_WILDCARD, '1);
		write_reg(REG_PAT_LEN, '1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h5A, 1'b1);

		// change the pattern in the middle of a region
		write_reg(REG_WILDCARD, '0);
		write_reg(REG_PAT_LEN, 64'd2);
		write_reg(REG_PAT_LOW, 64'h2211);
		send_byte(8'h11, 1'b0);
		write_reg(REG_PAT_LOW, 64'h3311);
		send_byte(8'h33, 1'b0);
		send_byte(8'h55, 1'b1);

		// spare indexes leave every register alone
		write_reg(REG_SPARE_A, '1);
		write_reg(REG_SPARE_B, 64'd1);
		send_byte(8'h11, 1'b0);
		send_byte(8'h33, 1'b1);

		for (int ph = 0; ph < 11; ph++) begin
			style = (ph == 1) ? 2 : (ph == 2) ? 3 : $urandom_range(1);
			write_reg(REG_PAT_LOW, pattern_word(style));
			write_reg(REG_PAT_MID_LOW, pattern_word(style));
			write_reg(REG_PAT_MID_HIGH, pattern_word(style));
			write_reg(REG_PAT_HIGH, pattern_word(style));
			if (ph == 3)
				write_reg(REG_WILDCARD, '1);
			else if (ph == 4)
				write_reg(REG_WILDCARD, '0);
			else
				write_reg(REG_WILDCARD, {$urandom, $urandom & $urandom & $urandom});
			len_word = {$urandom, $urandom};
			case (ph)
				0: len_word[RAW_LEN_W-1:0] = RAW_LEN_W'(MAX_PATTERN);
				1: len_word[RAW_LEN_W-1:0] = RAW_LEN_W'(1);
				2: len_word[RAW_LEN_W-1:0] = '0;
				3: len_word[RAW_LEN_W-1:0] = RAW_LEN_W'(MAX_PATTERN + 1);
				4: len_word[RAW_LEN_W-1:0] = '1;
				default: len_word[RAW_LEN_W-1:0] = RAW_LEN_W'($urandom_range(1, MAX_PATTERN));
			endcase
			write_reg(REG_PAT_LEN, len_word);
			if (ph == 6) write_reg(REG_SPARE_A, {$urandom, $urandom});

			steady = (ph == 5);
			goal   = items_sent + 135;
			while (items_sent < goal) begin
				if ($urandom_range(9) == 0)
					span = $urandom_range(1, 90);
				else
					span = $urandom_range(1, board.pattern_span() + 12);
				scan_region(span);
				if ($urandom_range(19) == 0) drain();
			end
			steady = 1'b0;
		end

		drain();
		repeat (8) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("PASS masked_byte_pattern_scan");
		else
			$display("FAIL masked_byte_pattern_scan");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mbps_pkg.sv
rtl/mbps_cell.sv
rtl/mbps_cell_row.sv
rtl/mbps_out_buf.sv
rtl/masked_byte_pattern_scan.sv
test/masked_byte_pattern_scan_test.sv
